// ===== src/tcaoq_pkg.sv =====
// Package: request and response words, request codes and controller states.
package tcaoq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 16;
  localparam int FIELD_ID_W      = 16;
  localparam int COUNT_W         = 5;

  localparam logic CLASS_A = 1'b0;
  localparam logic CLASS_B = 1'b1;

  typedef enum logic [1:0] {
    REQ_ENQ     = 2'd0,
    REQ_DEQ_ANY = 2'd1,
    REQ_DEQ_A   = 2'd2,
    REQ_DEQ_B   = 2'd3
  } req_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    req_kind_t               req_type;
    logic                    entry_class;
    logic [FIELD_ID_W-1:0]   entry_id;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic                    full_refused;
    logic                    out_class;
    logic [FIELD_ID_W-1:0]   out_id;
    logic [COUNT_W-1:0]      count_a;
    logic [COUNT_W-1:0]      count_b;
    logic                    queue_empty;
  } rsp_t;

endpackage

// ===== src/two_class_age_ordered_queue_unit.sv =====
// Two-class arrival-ordered queue: entry memory with scan-and-compact controller.
// Enqueue: the word is accepted while idle and the response is strobed in the next cycle.
// Dequeue: one memory read per held entry, with the compacting
//   write of each later entry issued on the same pass through the single RAM port pair.
// Dequeue on an empty queue answers in the next cycle. busy is high during the scan.
// Reset (rst, synchronous) clears the counts and controller; entry memory is not cleared.
module two_class_age_ordered_queue_unit #(
  parameter int QUEUE_DEPTH = tcaoq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = tcaoq_pkg::ID_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tcaoq_pkg::req_t req,
  output logic            done,
  output tcaoq_pkg::rsp_t rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int FW = tcaoq_pkg::FIELD_ID_W;
  localparam int KW = tcaoq_pkg::COUNT_W;

  logic [ID_WIDTH:0] mem [QUEUE_DEPTH];
  logic [ID_WIDTH:0] rdata;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [ID_WIDTH:0] wdata;

  tcaoq_pkg::state_t    state, state_next;
  tcaoq_pkg::req_kind_t req_kind, req_kind_next;
  logic [CW-1:0]        cnt_a, cnt_a_next, cnt_b, cnt_b_next;
  logic [AW-1:0]        idx, idx_next;
  logic                 hit, hit_next;
  logic                 hit_cls, hit_cls_next;
  logic [ID_WIDTH-1:0]  hit_id, hit_id_next;
  logic                 done_next;
  tcaoq_pkg::rsp_t      rsp_next;

  logic [CW-1:0]          total;
  logic                   accept;
  logic                   full;
  logic                   last;
  logic                   match;
  logic                   take_cls;
  logic [ID_WIDTH-1:0]    take_id;
  logic [ID_WIDTH+FW-1:0] id_in_ext;
  logic [ID_WIDTH+FW-1:0] id_out_ext;
  logic [CW+KW-1:0]       ca_ext, cb_ext;

  assign total     = cnt_a + cnt_b;
  assign accept    = start && !busy;
  assign full      = (total == CW'(QUEUE_DEPTH));
  assign last      = (CW'(idx) == (total - CW'(1)));
  assign id_in_ext = {{ID_WIDTH{1'b0}}, req.entry_id};

  always_comb begin
    case (req_kind)
      tcaoq_pkg::REQ_DEQ_ANY: match = 1'b1;
      tcaoq_pkg::REQ_DEQ_A:   match = (rdata[ID_WIDTH] == tcaoq_pkg::CLASS_A);
      tcaoq_pkg::REQ_DEQ_B:   match = (rdata[ID_WIDTH] == tcaoq_pkg::CLASS_B);
      default:                match = 1'b0;
    endcase
  end

  assign take_cls   = hit ? hit_cls : rdata[ID_WIDTH];
  assign take_id    = hit ? hit_id : rdata[ID_WIDTH-1:0];
  assign id_out_ext = {{FW{1'b0}}, take_id};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tcaoq_pkg::ST_IDLE: begin
        if (accept && req.req_type != tcaoq_pkg::REQ_ENQ && total != '0) begin
          state_next = tcaoq_pkg::ST_SCAN;
        end
      end
      tcaoq_pkg::ST_SCAN: begin
        if (last) begin
          state_next = tcaoq_pkg::ST_IDLE;
        end
      end
      default: state_next = tcaoq_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy          = (state != tcaoq_pkg::ST_IDLE);
    we            = 1'b0;
    waddr         = idx - AW'(1);
    wdata         = rdata;
    rd_addr       = idx + AW'(1);
    idx_next      = idx;
    req_kind_next = req_kind;
    hit_next      = hit;
    hit_cls_next  = hit_cls;
    hit_id_next   = hit_id;
    cnt_a_next    = cnt_a;
    cnt_b_next    = cnt_b;
    done_next     = 1'b0;
    rsp_next      = '0;
    case (state)
      tcaoq_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          req_kind_next = req.req_type;
          idx_next      = '0;
          hit_next      = 1'b0;
          if (req.req_type == tcaoq_pkg::REQ_ENQ) begin
            done_next = 1'b1;
            if (full) begin
              rsp_next.full_refused = 1'b1;
            end else begin
              we             = 1'b1;
              waddr          = total[AW-1:0];
              wdata          = {req.entry_class, id_in_ext[ID_WIDTH-1:0]};
              rsp_next.found = 1'b1;
              if (req.entry_class == tcaoq_pkg::CLASS_B) begin
                cnt_b_next = cnt_b + CW'(1);
              end else begin
                cnt_a_next = cnt_a + CW'(1);
              end
            end
          end else if (total == '0) begin
            done_next = 1'b1;
          end
        end
      end
      tcaoq_pkg::ST_SCAN: begin
        idx_next = idx + AW'(1);
        if (hit) begin
          we = 1'b1;
        end else if (match) begin
          hit_next     = 1'b1;
          hit_cls_next = rdata[ID_WIDTH];
          hit_id_next  = rdata[ID_WIDTH-1:0];
        end
        if (last) begin
          done_next = 1'b1;
          if (hit || match) begin
            rsp_next.found     = 1'b1;
            rsp_next.out_class = take_cls;
            rsp_next.out_id    = id_out_ext[FW-1:0];
            if (take_cls == tcaoq_pkg::CLASS_B) begin
              cnt_b_next = cnt_b - CW'(1);
            end else begin
              cnt_a_next = cnt_a - CW'(1);
            end
          end
        end
      end
      default: ;
    endcase
    ca_ext               = {{KW{1'b0}}, cnt_a_next};
    cb_ext               = {{KW{1'b0}}, cnt_b_next};
    rsp_next.count_a     = ca_ext[KW-1:0];
    rsp_next.count_b     = cb_ext[KW-1:0];
    rsp_next.queue_empty = ((cnt_a_next + cnt_b_next) == '0);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcaoq_pkg::ST_IDLE;
      cnt_a <= '0;
      cnt_b <= '0;
      done  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      cnt_a <= cnt_a_next;
      cnt_b <= cnt_b_next;
      done  <= done_next;
      hit   <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    req_kind <= req_kind_next;
    hit_cls  <= hit_cls_next;
    hit_id   <= hit_id_next;
    rsp      <= rsp_next;
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == tcaoq_pkg::ST_SCAN) |-> (total != '0))
    else $error("scan running on empty queue");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == tcaoq_pkg::REQ_ENQ && full) |=>
      (done && rsp.full_refused && !rsp.found))
    else $error("enqueue on full store not refused");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.found && rsp.full_refused))
    else $error("found and refused both set");

endmodule
